// ----- design/trd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the touch report decoder.
// Depends on nothing; the decoder top level refers to it by scoped names.
package trd_pkg;

   // Report layout.
   localparam int MAX_POINTS_DEFAULT = 2;
   localparam int BYTES_PER_POINT    = 6;
   localparam int OFS_W              = 3;
   localparam int COORD_W            = 12;

   // Byte offsets inside one point record.
   localparam logic [OFS_W-1:0] OFS_X_HIGH   = 3'd0;
   localparam logic [OFS_W-1:0] OFS_X_LOW    = 3'd1;
   localparam logic [OFS_W-1:0] OFS_Y_HIGH   = 3'd2;
   localparam logic [OFS_W-1:0] OFS_Y_LOW    = 3'd3;
   localparam logic [OFS_W-1:0] OFS_PRESSURE = 3'd4;
   localparam logic [OFS_W-1:0] OFS_LAST     = OFS_W'(BYTES_PER_POINT - 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_X_LIMIT        = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_Y_LIMIT        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SWAP_AXES      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MIRROR_H       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MIRROR_V       = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_POINT_CAPACITY = 3'd5;

   localparam logic [COORD_W-1:0] LIMIT_RESET    = 12'hFFF;
   localparam logic [1:0]         CAPACITY_RESET = 2'd2;

   // The fields of one point that the results use; byte 5 is dropped.
   typedef struct packed {
      logic [3:0] x_high;
      logic [7:0] x_low;
      logic [7:0] y_high;    // high nibble is the touch id
      logic [7:0] y_low;
      logic [7:0] pressure;
   } point_type;

   function automatic logic [COORD_W-1:0] mirror_axis(input logic [COORD_W-1:0] v,
                                                      input logic [COORD_W-1:0] lim);
      mirror_axis = (v > lim) ? '0 : lim - v;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_axis(input logic [COORD_W-1:0] v,
                                                     input logic [COORD_W-1:0] lim);
      clamp_axis = (v > lim) ? lim : v;
   endfunction

endpackage

// ----- design/touch_report_decoder.sv -----
`timescale 1ns / 1ps
// Touch report decoder top level: byte collector, point bank, result stage
// and configuration registers. Depends on trd_pkg for constants and types.
//
// The req channel carries one report byte per word, with req_frame_start
// marking the status byte. A report is the status byte and then six bytes for
// each of MAX_POINTS point slots. Bytes seen outside a frame are dropped, and
// a frame start in the middle of a report restarts collection.
// The rsp channel returns one word per reported point once the final report
// byte is accepted, or a single word with rsp_point_valid low when the frame
// holds no points. The first result word is registered after the final byte
// starts the emitter, and the following ones one per cycle while rsp_ready is
// high. The block takes one byte per cycle. It stalls a byte only while the
// final byte of a report is due and results of the previous frame are still
// being delivered, since the completed frame is copied into the single result
// bank when that byte is accepted; a frame start offered then waits as well.
// A stalled receiver holds the result word in the output register; the
// collector keeps taking the bytes of the next report meanwhile.
// Reset clears the frame and result state and returns the registers to their
// defaults (both limits 4095, no swap, no mirroring, capacity two).
// The csr port is APB style with no wait states: x_limit at 0x00, y_limit at
// 0x04, swap_axes 0x08, mirror_horizontal 0x0C, mirror_vertical 0x10, point_capacity
// 0x14. Registers must be written only while the block is idle; it does not check this.
module touch_report_decoder #(
   parameter int MAX_POINTS = trd_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input byte channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_report_byte,
   input  logic                            req_frame_start,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_point_valid,
   output logic [trd_pkg::COORD_W-1:0]     rsp_x_coord,
   output logic [trd_pkg::COORD_W-1:0]     rsp_y_coord,
   output logic [7:0]                      rsp_pressure,
   output logic [3:0]                      rsp_touch_id,
   output logic [1:0]                      rsp_point_count,
   output logic                            rsp_last,
   // Configuration port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [trd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [trd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [trd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int PT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = trd_pkg::COORD_W;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [CW-1:0] x_limit_ff;
   logic [CW-1:0] y_limit_ff;
   logic          swap_axes_ff;
   logic          mirror_h_ff;
   logic          mirror_v_ff;
   logic [1:0]    capacity_ff;

   logic                            csr_write;
   logic [trd_pkg::REG_IDX_W-1:0]   csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[trd_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff   <= trd_pkg::LIMIT_RESET;
         y_limit_ff   <= trd_pkg::LIMIT_RESET;
         swap_axes_ff <= 1'b0;
         mirror_h_ff  <= 1'b0;
         mirror_v_ff  <= 1'b0;
         capacity_ff  <= trd_pkg::CAPACITY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            trd_pkg::REG_X_LIMIT:        x_limit_ff   <= csr_pwdata[CW-1:0];
            trd_pkg::REG_Y_LIMIT:        y_limit_ff   <= csr_pwdata[CW-1:0];
            trd_pkg::REG_SWAP_AXES:      swap_axes_ff <= csr_pwdata[0];
            trd_pkg::REG_MIRROR_H:       mirror_h_ff  <= csr_pwdata[0];
            trd_pkg::REG_MIRROR_V:       mirror_v_ff  <= csr_pwdata[0];
            trd_pkg::REG_POINT_CAPACITY: capacity_ff  <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         trd_pkg::REG_X_LIMIT:        csr_prdata[CW-1:0] = x_limit_ff;
         trd_pkg::REG_Y_LIMIT:        csr_prdata[CW-1:0] = y_limit_ff;
         trd_pkg::REG_SWAP_AXES:      csr_prdata[0]      = swap_axes_ff;
         trd_pkg::REG_MIRROR_H:       csr_prdata[0]      = mirror_h_ff;
         trd_pkg::REG_MIRROR_V:       csr_prdata[0]      = mirror_v_ff;
         trd_pkg::REG_POINT_CAPACITY: csr_prdata[1:0]    = capacity_ff;
         default:                     csr_prdata         = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Byte collector. The point slot and the byte offset inside it are kept
   // as two counters, so a byte lands in its field without any division.
   // ---------------------------------------------------------------------
   logic                     frame_active_ff;
   logic [3:0]               raw_count_ff;
   logic [PT_W-1:0]          pt_idx_ff;
   logic [trd_pkg::OFS_W-1:0] ofs_ff;
   trd_pkg::point_type       work_bank_ff [MAX_POINTS];

   logic in_accept;
   logic final_next;
   logic frame_done;

   // The next data byte of the frame is its final byte.
   assign final_next = frame_active_ff && (ofs_ff == trd_pkg::OFS_LAST) &&
                       (pt_idx_ff == PT_W'(MAX_POINTS - 1));

   // Result-side state, declared here because the ready term needs it.
   logic emit_busy_ff;

   assign req_ready  = !(final_next && emit_busy_ff);
   assign in_accept  = req_valid && req_ready;
   assign frame_done = in_accept && !req_frame_start && final_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
      end else if (in_accept) begin
         if (req_frame_start) begin
            frame_active_ff <= 1'b1;
         end else if (final_next) begin
            frame_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         if (req_frame_start) begin
            raw_count_ff <= req_report_byte[3:0];
            pt_idx_ff    <= '0;
            ofs_ff       <= '0;
         end else if (frame_active_ff) begin
            case (ofs_ff)
               trd_pkg::OFS_X_HIGH:   work_bank_ff[pt_idx_ff].x_high   <= req_report_byte[3:0];
               trd_pkg::OFS_X_LOW:    work_bank_ff[pt_idx_ff].x_low    <= req_report_byte;
               trd_pkg::OFS_Y_HIGH:   work_bank_ff[pt_idx_ff].y_high   <= req_report_byte;
               trd_pkg::OFS_Y_LOW:    work_bank_ff[pt_idx_ff].y_low    <= req_report_byte;
               trd_pkg::OFS_PRESSURE: work_bank_ff[pt_idx_ff].pressure <= req_report_byte;
               default: ;
            endcase
            if (ofs_ff == trd_pkg::OFS_LAST) begin
               ofs_ff <= '0;
               if (pt_idx_ff != PT_W'(MAX_POINTS - 1)) begin
                  pt_idx_ff <= pt_idx_ff + 1'b1;
               end
            end else begin
               ofs_ff <= ofs_ff + 1'b1;
            end
         end
      end
   end

   // Point count after the limits: a count above the slot count reads as
   // zero, then it is capped by the capacity, where zero capacity means one.
   logic [1:0] cap_eff;
   logic [1:0] frame_count;

   always_comb begin
      cap_eff = (capacity_ff == 2'd0) ? 2'd1 : capacity_ff;
      if (raw_count_ff > 4'(MAX_POINTS)) begin
         frame_count = 2'd0;
      end else if (raw_count_ff > {2'b00, cap_eff}) begin
         frame_count = cap_eff;
      end else begin
         frame_count = raw_count_ff[1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Result bank and emitter. A finished frame is copied into the result
   // bank so the collector can start filling the next report at once.
   // ---------------------------------------------------------------------
   trd_pkg::point_type out_bank_ff [MAX_POINTS];
   logic [1:0]         emit_count_ff;
   logic [1:0]         emit_left_ff;
   logic [PT_W-1:0]    emit_idx_ff;

   logic rsp_valid_ff;
   logic out_load;
   logic emit_step;
   logic emit_last;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign emit_step = emit_busy_ff && out_load;
   assign emit_last = (emit_count_ff == 2'd0) || (emit_left_ff == 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_busy_ff <= 1'b0;
      end else if (frame_done) begin
         emit_busy_ff <= 1'b1;
      end else if (emit_step && emit_last) begin
         emit_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         out_bank_ff   <= work_bank_ff;
         emit_count_ff <= frame_count;
         emit_left_ff  <= frame_count;
         emit_idx_ff   <= '0;
      end else if (emit_step && !emit_last) begin
         emit_left_ff <= emit_left_ff - 2'd1;
         emit_idx_ff  <= emit_idx_ff + 1'b1;
      end
   end

   // Coordinate transform for the point being emitted: swap, then mirror,
   // then clamp against the limits.
   trd_pkg::point_type cur_point;
   logic [CW-1:0]      raw_x;
   logic [CW-1:0]      raw_y;
   logic [CW-1:0]      sw_x;
   logic [CW-1:0]      sw_y;
   logic [CW-1:0]      mir_x;
   logic [CW-1:0]      mir_y;

   always_comb begin
      cur_point = out_bank_ff[emit_idx_ff];
      raw_x     = {cur_point.x_high, cur_point.x_low};
      raw_y     = {cur_point.y_high[3:0], cur_point.y_low};
      sw_x      = swap_axes_ff ? raw_y : raw_x;
      sw_y      = swap_axes_ff ? raw_x : raw_y;
      mir_x     = mirror_h_ff ? trd_pkg::mirror_axis(sw_x, x_limit_ff) : sw_x;
      mir_y     = mirror_v_ff ? trd_pkg::mirror_axis(sw_y, y_limit_ff) : sw_y;
   end

   // Output register.
   logic          rsp_point_valid_ff;
   logic [CW-1:0] rsp_x_coord_ff;
   logic [CW-1:0] rsp_y_coord_ff;
   logic [7:0]    rsp_pressure_ff;
   logic [3:0]    rsp_touch_id_ff;
   logic [1:0]    rsp_point_count_ff;
   logic          rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= emit_busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_step) begin
         rsp_point_count_ff <= emit_count_ff;
         rsp_last_ff        <= emit_last;
         if (emit_count_ff == 2'd0) begin
            // A frame without points reports one empty word.
            rsp_point_valid_ff <= 1'b0;
            rsp_x_coord_ff     <= '0;
            rsp_y_coord_ff     <= '0;
            rsp_pressure_ff    <= '0;
            rsp_touch_id_ff    <= '0;
         end else begin
            rsp_point_valid_ff <= 1'b1;
            rsp_x_coord_ff     <= trd_pkg::clamp_axis(mir_x, x_limit_ff);
            rsp_y_coord_ff     <= trd_pkg::clamp_axis(mir_y, y_limit_ff);
            rsp_pressure_ff    <= cur_point.pressure;
            rsp_touch_id_ff    <= cur_point.y_high[7:4];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_valid = rsp_point_valid_ff;
   assign rsp_x_coord     = rsp_x_coord_ff;
   assign rsp_y_coord     = rsp_y_coord_ff;
   assign rsp_pressure    = rsp_pressure_ff;
   assign rsp_touch_id    = rsp_touch_id_ff;
   assign rsp_point_count = rsp_point_count_ff;
   assign rsp_last        = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // An empty word is always the only and final word of its frame.
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_point_valid) |-> (rsp_last && rsp_point_count == 2'd0))
      else $error("empty result word without last or with a nonzero count");

   // A point word stays within the configured limits and a nonzero count.
   a_point_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_point_valid) |->
         (rsp_point_count != 2'd0 && rsp_x_coord <= x_limit_ff &&
          rsp_y_coord <= y_limit_ff))
      else $error("point word out of limits or with zero count");

   // A completed frame starts the emitter and leaves the collector idle.
   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (emit_busy_ff && !frame_active_ff))
      else $error("completed frame did not hand over to the emitter");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for touch_report_decoder: streams report bytes,
// programs the registers over APB and checks every result word against its own
// decode of each report. Depends on trd_pkg and the decoder RTL.
module tb_top;

   // Report geometry as the block is built here.
   localparam int POINT_SLOTS = trd_pkg::MAX_POINTS_DEFAULT;
   localparam int BODY_BYTES  = POINT_SLOTS * trd_pkg::BYTES_PER_POINT;
   localparam int REPORT_LEN  = 1 + BODY_BYTES;

   // Cycles left for trailing work before a register write, cycles watched for
   // stray results at the end, and the number of cycles without any handshake
   // that counts as a hang.
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_LIMIT   = 2000;

   // The point bytes of one report, first byte in the most significant position.
   typedef logic [BODY_BYTES*8-1:0] report_body_type;

   // One result word as it should appear on the rsp channel.
   typedef struct packed {
      logic                        point_valid;
      logic [trd_pkg::COORD_W-1:0] x_coord;
      logic [trd_pkg::COORD_W-1:0] y_coord;
      logic [7:0]                  pressure;
      logic [3:0]                  touch_id;
      logic [1:0]                  point_count;
      logic                        is_last;
   } point_word_type;

   // All inputs start at known values; reset is held from time zero.
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_report_byte = '0;
   logic                           req_frame_start = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_point_valid;
   logic [trd_pkg::COORD_W-1:0]    rsp_x_coord;
   logic [trd_pkg::COORD_W-1:0]    rsp_y_coord;
   logic [7:0]                     rsp_pressure;
   logic [3:0]                     rsp_touch_id;
   logic [1:0]                     rsp_point_count;
   logic                           rsp_last;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [trd_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [trd_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [trd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   touch_report_decoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_report_byte (req_report_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_valid (rsp_point_valid),
      .rsp_x_coord     (rsp_x_coord),
      .rsp_y_coord     (rsp_y_coord),
      .rsp_pressure    (rsp_pressure),
      .rsp_touch_id    (rsp_touch_id),
      .rsp_point_count (rsp_point_count),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // Shadow copy of the configuration registers, updated on every write.
   logic [trd_pkg::COORD_W-1:0] lim_x = trd_pkg::LIMIT_RESET;
   logic [trd_pkg::COORD_W-1:0] lim_y = trd_pkg::LIMIT_RESET;
   logic                        swap_xy = 1'b0;
   logic                        flip_x = 1'b0;
   logic                        flip_y = 1'b0;
   logic [1:0]                  capacity_cfg = trd_pkg::CAPACITY_RESET;

   // Shadow of the byte collector: position in the report, whether a report
   // is open, the count nibble of its status byte and the point bytes so far.
   int unsigned        body_pos = 0;
   logic               in_frame = 1'b0;
   logic [3:0]         status_count = '0;
   logic [7:0]         body_store [BODY_BYTES];

   // Result words predicted but not yet seen, oldest first.
   point_word_type     pending_points [$];

   int                 mismatch_count = 0;

   // When clear, neither the byte sender nor the result receiver inserts gaps.
   logic               idle_enable = 1'b1;
   int                 stall_left = 0;

   // Follows one accepted byte through the report layout. When the byte
   // completes a report, the count is limited, the points are transformed
   // with the current register values and the expected words are queued.
   task automatic decode_report_byte(input logic [7:0] b, input logic fs);
      int unsigned                 n;
      int unsigned                 cap;
      int                          i;
      int                          base;
      logic [trd_pkg::COORD_W-1:0] x;
      logic [trd_pkg::COORD_W-1:0] y;
      logic [trd_pkg::COORD_W-1:0] t;
      point_word_type              w;
      // A frame start always opens a new report, even in the middle of one.
      if (fs) begin
         status_count = b[3:0];
         body_pos = 1;
         in_frame = 1'b1;
         return;
      end
      // Bytes outside a report are dropped.
      if (!in_frame)
         return;
      body_store[body_pos-1] = b;
      body_pos++;
      if (body_pos < REPORT_LEN)
         return;
      in_frame = 1'b0;
      body_pos = 0;
      // A count the point slots cannot hold means no points; a capacity of
      // zero behaves as one.
      n = (int'(status_count) > POINT_SLOTS) ? 0 : 32'(status_count);
      cap = (capacity_cfg == 2'd0) ? 1 : 32'(capacity_cfg);
      if (n > cap)
         n = cap;
      if (n == 0) begin
         w = '0;
         w.is_last = 1'b1;
         pending_points.push_back(w);
         return;
      end
      for (i = 0; i < n; i++) begin
         base = i * trd_pkg::BYTES_PER_POINT;
         x = {body_store[base + trd_pkg::OFS_X_HIGH][3:0],
              body_store[base + trd_pkg::OFS_X_LOW]};
         y = {body_store[base + trd_pkg::OFS_Y_HIGH][3:0],
              body_store[base + trd_pkg::OFS_Y_LOW]};
         if (swap_xy) begin
            t = x;
            x = y;
            y = t;
         end
         // Mirroring a value past the limit lands on zero.
         if (flip_x)
            x = (x > lim_x) ? '0 : lim_x - x;
         if (flip_y)
            y = (y > lim_y) ? '0 : lim_y - y;
         if (x > lim_x)
            x = lim_x;
         if (y > lim_y)
            y = lim_y;
         w.point_valid = 1'b1;
         w.x_coord     = x;
         w.y_coord     = y;
         w.pressure    = body_store[base + trd_pkg::OFS_PRESSURE];
         w.touch_id    = body_store[base + trd_pkg::OFS_Y_HIGH][7:4];
         w.point_count = 2'(n);
         w.is_last     = (i + 1 == n);
         pending_points.push_back(w);
      end
   endtask

   // Offers one byte on the req channel and returns at the edge that takes it.
   // Valid is left high so that a following call in the same time step only
   // swaps the payload; anyone who pauses afterwards lowers it first.
   task automatic send_byte(input logic [7:0] b, input logic fs);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_report_byte <= b;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      decode_report_byte(b, fs);
   endtask

   // Sends a status byte and the first body_len bytes of the point body; a
   // short body_len leaves the report open for the next frame start to drop.
   task automatic send_report(input logic [7:0] status, input report_body_type body,
                              input int body_len);
      int k;
      send_byte(status, 1'b1);
      for (k = 0; k < body_len; k++)
         send_byte(body[8*(BODY_BYTES-1-k) +: 8], 1'b0);
   endtask

   function automatic report_body_type random_body();
      report_body_type body;
      int              k;
      for (k = 0; k < BODY_BYTES; k++)
         body[8*k +: 8] = 8'($urandom);
      return body;
   endfunction

   // Status bytes mostly carry a count the block can report, now and then one
   // above the slot count. The high nibble is random.
   function automatic logic [7:0] random_status();
      int          sel;
      logic [3:0]  count;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         count = 4'd0;
      else if (sel <= 3)
         count = 4'd1;
      else if (sel <= 7)
         count = 4'd2;
      else
         count = 4'($urandom_range(POINT_SLOTS + 1, 15));
      return {4'($urandom), count};
   endfunction

   function automatic logic [trd_pkg::COORD_W-1:0] random_limit();
      case ($urandom_range(0, 3))
         0: return trd_pkg::LIMIT_RESET;
         1: return trd_pkg::COORD_W'($urandom_range(0, 15));
         default: return trd_pkg::COORD_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // Complete reports with random content. With noise, some are preceded by
   // stray bytes outside any report or by a report cut short by a new start.
   task automatic send_random_frames(input int frames, input logic with_noise);
      int f;
      int k;
      int sel;
      int strays;
      for (f = 0; f < frames; f++) begin
         sel = with_noise ? $urandom_range(0, 7) : 7;
         if (sel == 0) begin
            strays = $urandom_range(1, 3);
            for (k = 0; k < strays; k++)
               send_byte(8'($urandom), 1'b0);
         end else if (sel == 1) begin
            send_report(random_status(), random_body(), $urandom_range(0, BODY_BYTES - 1));
         end
         send_report(random_status(), random_body(), BODY_BYTES);
      end
   endtask

   // Returns once every predicted word has arrived and the block has had time
   // to finish anything that produces no word.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB write: a setup cycle, then an access cycle that completes at the
   // edge where pready is high. psel is left high so back-to-back writes do
   // not drive it twice in one time step.
   task automatic write_reg(input logic [trd_pkg::REG_IDX_W-1:0] idx,
                            input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= trd_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         trd_pkg::REG_X_LIMIT:        lim_x = value[trd_pkg::COORD_W-1:0];
         trd_pkg::REG_Y_LIMIT:        lim_y = value[trd_pkg::COORD_W-1:0];
         trd_pkg::REG_SWAP_AXES:      swap_xy = value[0];
         trd_pkg::REG_MIRROR_H:       flip_x = value[0];
         trd_pkg::REG_MIRROR_V:       flip_y = value[0];
         trd_pkg::REG_POINT_CAPACITY: capacity_cfg = value[1:0];
         default: ;
      endcase
   endtask

   // Writes all six registers while the block is idle. With junk set, the
   // bits above each register's width carry random values the block ignores.
   task automatic apply_config(input logic [trd_pkg::COORD_W-1:0] xl,
                               input logic [trd_pkg::COORD_W-1:0] yl,
                               input logic sw, input logic mh, input logic mv,
                               input logic [1:0] cap, input logic junk);
      logic [31:0] upper;
      upper = junk ? $urandom : 32'd0;
      wait_idle();
      write_reg(trd_pkg::REG_X_LIMIT,        {upper[31:trd_pkg::COORD_W], xl});
      write_reg(trd_pkg::REG_Y_LIMIT,        {upper[31:trd_pkg::COORD_W], yl});
      write_reg(trd_pkg::REG_SWAP_AXES,      {upper[31:1], sw});
      write_reg(trd_pkg::REG_MIRROR_H,       {upper[31:1], mh});
      write_reg(trd_pkg::REG_MIRROR_V,       {upper[31:1], mv});
      write_reg(trd_pkg::REG_POINT_CAPACITY, {upper[31:2], cap});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Short directed sequence under the reset register values: two points at
   // opposite extremes with ignored high nibbles set, stray bytes after a
   // finished report, a report cut short by a new frame start, and a status
   // count above the slot count that must come back as a single empty word.
   task automatic test_directed_reports();
      send_report(8'hF2, 96'hFFFF_FFFF_FFFF_0000_0000_0000, BODY_BYTES);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_report(8'h01, random_body(), 3);
      send_report(8'h03, random_body(), BODY_BYTES);
   endtask

   // Steps through fixed register settings that reach the extremes: zero and
   // full-scale limits, every swap and mirror combination that matters, and
   // capacities zero through three.
   task automatic test_transform_settings();
      int s;
      for (s = 0; s < 6; s++) begin
         case (s)
            0: apply_config(12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, 2'd2, 1'b0);
            1: apply_config(12'd0,    12'd0,    1'b1, 1'b1, 1'b1, 2'd0, 1'b0);
            2: apply_config(12'd4095, 12'd4095, 1'b1, 1'b1, 1'b0, 2'd1, 1'b0);
            3: apply_config(12'd1000, 12'd3000, 1'b0, 1'b0, 1'b1, 2'd3, 1'b0);
            4: apply_config(12'd2048, 12'd100,  1'b1, 1'b1, 1'b1, 2'd2, 1'b0);
            default: apply_config(12'd4095, 12'd0, 1'b0, 1'b1, 1'b0, 2'd2, 1'b0);
         endcase
         send_random_frames(3, 1'b0);
      end
   endtask

   // Random register settings, each followed by random reports mixed with
   // stray bytes and cut-short reports. Some phases run without gaps.
   task automatic test_random_reports();
      int p;
      for (p = 0; p < 4; p++) begin
         apply_config(random_limit(), random_limit(), 1'($urandom), 1'($urandom),
                      1'($urandom), 2'($urandom), 1'b1);
         idle_enable = ($urandom_range(0, 3) != 0);
         send_random_frames($urandom_range(6, 8), 1'b1);
      end
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_steady_stream();
      apply_config(random_limit(), random_limit(), 1'($urandom), 1'($urandom),
                   1'($urandom), 2'($urandom), 1'b1);
      idle_enable = 1'b0;
      send_random_frames(8, 1'b1);
   endtask

   // Result receiver: ready drops for bursts of random length while gaps are
   // enabled, and stays high otherwise.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Every word taken from the rsp channel is matched against the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      point_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got x=%0d y=%0d",
                     $time, rsp_x_coord, rsp_y_coord);
            mismatch_count++;
         end else begin
            want = pending_points.pop_front();
            check_field("point_valid", 32'(want.point_valid), 32'(rsp_point_valid));
            check_field("x_coord",     32'(want.x_coord),     32'(rsp_x_coord));
            check_field("y_coord",     32'(want.y_coord),     32'(rsp_y_coord));
            check_field("pressure",    32'(want.pressure),    32'(rsp_pressure));
            check_field("touch_id",    32'(want.touch_id),    32'(rsp_touch_id));
            check_field("point_count", 32'(want.point_count), 32'(rsp_point_count));
            check_field("last",        32'(want.is_last),     32'(rsp_last));
         end
      end
   end

   // Hang detection: any accepted byte, result word or register access counts
   // as progress.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_reports();
      test_transform_settings();
      test_random_reports();
      test_steady_stream();
      // Let the last words drain, then watch a little longer for extras.
      req_valid <= 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
